/* rtl/crtc_pkg.sv */
// ----------------------------------------------------------------------------
// crtc_pkg
// Shared types, constants and helper functions of the crt controller timing
// unit.
// ----------------------------------------------------------------------------
`default_nettype none

package crtc_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_PEN   = 2'd3
    } t_action;

    localparam int unsigned NUM_STORED = 18;
    localparam int unsigned PEN_HI_REG = 16;
    localparam int unsigned PEN_LO_REG = 17;
    localparam logic [7:0]  MAX_SCAN_RESET = 8'd10;
    localparam logic [4:0]  VSYNC_FULL = 5'd17;

    // decoded control register fields used by the timing logic
    typedef struct packed {
        logic [7:0]  h_total;
        logic [7:0]  h_displayed;
        logic [7:0]  h_sync_pos;
        logic [3:0]  v_sync_width;
        logic [6:0]  v_total;
        logic [4:0]  v_adjust;
        logic [6:0]  v_displayed;
        logic [6:0]  v_sync_pos;
        logic [1:0]  mode;
        logic [4:0]  max_scan;
        logic [6:0]  cursor_start;
        logic [4:0]  cursor_end;
        logic [13:0] start_addr;
        logic [13:0] cursor_addr;
    } t_crtc_cfg;

    typedef struct packed {
        logic [13:0] mem_address;
        logic [4:0]  row_address;
        logic        display_enable;
        logic        cursor_active;
        logic        hsync_start;
        logic        vsync_level;
        logic        odd_field;
    } t_tim_res;

    function automatic logic [7:0] reg_mask(input logic [4:0] idx);
        logic [7:0] m;
        unique case (idx)
            5'd0, 5'd1, 5'd2, 5'd3:   m = 8'hFF;
            5'd4, 5'd6, 5'd7, 5'd10:  m = 8'h7F;
            5'd5, 5'd9, 5'd11:        m = 8'h1F;
            5'd8:                     m = 8'hF3;
            5'd12, 5'd14, 5'd16:      m = 8'h3F;
            5'd13, 5'd15, 5'd17:      m = 8'hFF;
            default:                  m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic line_match(input logic [4:0] scan, input logic [4:0] target,
                                        input logic il);
        return (scan == target) || (il && (scan == (target >> 1)));
    endfunction

endpackage

`default_nettype wire

/* rtl/crtc_if.sv */
// ----------------------------------------------------------------------------
// crtc_if
// Valid/ready channels of the crt controller timing unit: command words in,
// result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface crtc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       reg_select;
    logic [7:0] write_data;

    modport source (output valid, output action, output reg_select, output write_data,
                    input ready);
    modport sink   (input valid, input action, input reg_select, input write_data,
                    output ready);
endinterface

interface crtc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [13:0] mem_address;
    logic [4:0]  row_address;
    logic        display_enable;
    logic        cursor_active;
    logic        hsync_start;
    logic        vsync_level;
    logic        odd_field;

    modport source (output valid, output read_data, output mem_address,
                    output row_address, output display_enable, output cursor_active,
                    output hsync_start, output vsync_level, output odd_field,
                    input ready);
    modport sink   (input valid, input read_data, input mem_address,
                    input row_address, input display_enable, input cursor_active,
                    input hsync_start, input vsync_level, input odd_field,
                    output ready);
endinterface

`default_nettype wire

/* rtl/crtc_regfile.sv */
// ----------------------------------------------------------------------------
// crtc_regfile
// Index register and masked control registers with bus read, bus write and
// light pen capture.
// ----------------------------------------------------------------------------
`default_nettype none

module crtc_regfile (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  crtc_pkg::t_action      i_action,
    input  wire logic              i_reg_select,
    input  wire logic [7:0]        i_write_data,
    input  wire logic [13:0]       i_refresh_addr,
    output logic [7:0]             o_read_data,
    output crtc_pkg::t_crtc_cfg    o_cfg
);

    logic [4:0] r_index;
    logic [7:0] r_regs [crtc_pkg::NUM_STORED];
    logic [7:0] w_sel_reg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            for (int k = 0; k < crtc_pkg::NUM_STORED; k++) begin
                r_regs[k] <= '0;
            end
            r_regs[9] <= crtc_pkg::MAX_SCAN_RESET;
        end else if (i_step) begin
            if (i_action == crtc_pkg::ACT_WRITE) begin
                if (!i_reg_select) begin
                    r_index <= i_write_data[4:0];
                end else if (r_index < 5'(crtc_pkg::NUM_STORED)) begin
                    r_regs[r_index] <= i_write_data & crtc_pkg::reg_mask(r_index);
                end
            end else if (i_action == crtc_pkg::ACT_PEN) begin
                r_regs[crtc_pkg::PEN_HI_REG] <= {2'b00, i_refresh_addr[13:8]};
                r_regs[crtc_pkg::PEN_LO_REG] <= i_refresh_addr[7:0];
            end
        end
    end

    always_comb begin
        w_sel_reg = '0;
        if (r_index < 5'(crtc_pkg::NUM_STORED)) begin
            w_sel_reg = r_regs[r_index];
        end
    end

    always_comb begin
        o_read_data = '0;
        if (i_action == crtc_pkg::ACT_READ) begin
            o_read_data = i_reg_select ? w_sel_reg : {3'b000, r_index};
        end
    end

    assign o_cfg.h_total      = r_regs[0];
    assign o_cfg.h_displayed  = r_regs[1];
    assign o_cfg.h_sync_pos   = r_regs[2];
    assign o_cfg.v_sync_width = r_regs[3][7:4];
    assign o_cfg.v_total      = r_regs[4][6:0];
    assign o_cfg.v_adjust     = r_regs[5][4:0];
    assign o_cfg.v_displayed  = r_regs[6][6:0];
    assign o_cfg.v_sync_pos   = r_regs[7][6:0];
    assign o_cfg.mode         = r_regs[8][1:0];
    assign o_cfg.max_scan     = r_regs[9][4:0];
    assign o_cfg.cursor_start = r_regs[10][6:0];
    assign o_cfg.cursor_end   = r_regs[11][4:0];
    assign o_cfg.start_addr   = {r_regs[12][5:0], r_regs[13]};
    assign o_cfg.cursor_addr  = {r_regs[14][5:0], r_regs[15]};

endmodule

`default_nettype wire

/* rtl/crtc_timing.sv */
// ----------------------------------------------------------------------------
// crtc_timing
// Horizontal, row, scan line and adjust counters with display enable,
// cursor, blink, vsync and interlace field logic.
// ----------------------------------------------------------------------------
`default_nettype none

module crtc_timing (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tick,
    input  crtc_pkg::t_crtc_cfg    i_cfg,
    output crtc_pkg::t_tim_res     o_res,
    output logic [13:0]            o_refresh_addr
);

    logic [7:0]  r_h, n_h;
    logic [6:0]  r_row, n_row;
    logic [4:0]  r_scan, n_scan;
    logic [4:0]  r_adj, n_adj;
    logic [13:0] r_ra, n_ra;
    logic [13:0] r_rsa, n_rsa;
    logic        r_disp, n_disp;
    logic        r_vdisp, n_vdisp;
    logic        r_cl_on, n_cl_on;
    logic        r_cl_done, n_cl_done;
    logic        r_blink, n_blink;
    logic [5:0]  r_frame, n_frame;
    logic [4:0]  r_vs_left, n_vs_left;
    logic        r_vs_rel, n_vs_rel;
    logic        r_vs_out, n_vs_out;
    logic        r_fodd, n_fodd;
    logic        r_half, n_half;
    logic        r_field, n_field;

    always_comb begin
        logic       il;
        logic [6:0] old_row;
        logic       hs;
        logic       cur;
        il        = (i_cfg.mode == 2'b11);
        old_row   = r_row;
        hs        = 1'b0;
        cur       = 1'b0;
        n_h       = r_h;
        n_row     = r_row;
        n_scan    = r_scan;
        n_adj     = r_adj;
        n_ra      = r_ra;
        n_rsa     = r_rsa;
        n_disp    = r_disp;
        n_vdisp   = r_vdisp;
        n_cl_on   = r_cl_on;
        n_cl_done = r_cl_done;
        n_blink   = r_blink;
        n_frame   = r_frame;
        n_vs_left = r_vs_left;
        n_vs_rel  = r_vs_rel;
        n_vs_out  = r_vs_out;
        n_fodd    = r_fodd;
        n_half    = r_half;
        n_field   = r_field;

        if (i_tick) begin
            if (r_h == i_cfg.h_displayed) begin
                n_disp = 1'b0;
            end
            hs = (r_h == i_cfg.h_sync_pos);
            if (n_disp) begin
                cur  = (r_ra == i_cfg.cursor_addr) && r_cl_on && r_blink;
                n_ra = r_ra + 14'd1;
            end
            if (r_vs_rel) begin
                n_vs_rel = 1'b0;
                n_vs_out = 1'b0;
            end
            if (r_half && (r_h == (i_cfg.h_total >> 1))) begin
                n_h    = '0;
                n_half = 1'b0;
            end else if (r_h == i_cfg.h_total) begin
                // end of scan line
                n_h = '0;
                if (crtc_pkg::line_match(r_scan, i_cfg.cursor_end, il)) begin
                    n_cl_on   = 1'b0;
                    n_cl_done = 1'b1;
                end
                if (r_adj != '0) begin
                    n_scan = r_scan + 5'd1;
                    n_ra   = r_rsa;
                    n_adj  = r_adj - 5'd1;
                    if (n_adj == '0) begin
                        n_vdisp = 1'b1;
                        n_ra    = i_cfg.start_addr;
                        n_rsa   = i_cfg.start_addr;
                        n_scan  = '0;
                    end
                end else if (crtc_pkg::line_match(r_scan, i_cfg.max_scan, il)) begin
                    // end of character row
                    n_rsa     = n_ra;
                    n_scan    = '0;
                    n_cl_on   = 1'b0;
                    n_cl_done = 1'b0;
                    n_row     = r_row + 7'd1;
                    if (n_row == i_cfg.v_displayed) begin
                        n_vdisp = 1'b0;
                    end
                    if (old_row == i_cfg.v_total) begin
                        n_row = '0;
                        n_adj = i_cfg.v_adjust;
                        if (i_cfg.v_adjust == '0) begin
                            n_vdisp = 1'b1;
                            n_ra    = i_cfg.start_addr;
                            n_rsa   = i_cfg.start_addr;
                        end
                        n_frame = r_frame + 6'd1;
                        unique case (i_cfg.cursor_start[6:5])
                            2'd0:    n_blink = 1'b1;
                            2'd1:    n_blink = 1'b0;
                            2'd2:    n_blink = n_frame[4];
                            default: n_blink = n_frame[5];
                        endcase
                    end
                    if (n_row == i_cfg.v_sync_pos) begin
                        n_fodd = !r_fodd;
                        if (n_fodd) begin
                            n_half = i_cfg.mode[0];
                        end
                        n_field  = n_fodd && i_cfg.mode[0];
                        n_vs_out = 1'b1;
                        n_vs_left = (i_cfg.v_sync_width == '0) ? crtc_pkg::VSYNC_FULL
                                  : {1'b0, i_cfg.v_sync_width} + 5'd1;
                    end
                end else begin
                    n_scan = r_scan + 5'd1;
                    n_ra   = r_rsa;
                end
                if (crtc_pkg::line_match(n_scan, i_cfg.cursor_start[4:0], il)
                        && !n_cl_done) begin
                    n_cl_on = 1'b1;
                end
                if (n_vs_left != '0) begin
                    n_vs_left = n_vs_left - 5'd1;
                    if (n_vs_left == '0) begin
                        n_vs_rel = 1'b1;
                        if (n_fodd) begin
                            n_half = i_cfg.mode[0];
                        end
                    end
                end
                n_disp = n_vdisp;
            end else begin
                n_h = r_h + 8'd1;
            end
        end

        o_res.mem_address    = r_ra;
        o_res.row_address    = r_scan;
        o_res.display_enable = i_tick ? (r_disp && (r_h != i_cfg.h_displayed)) : r_disp;
        o_res.cursor_active  = cur;
        o_res.hsync_start    = hs;
        o_res.vsync_level    = n_vs_out;
        o_res.odd_field      = n_field;
    end

    assign o_refresh_addr = r_ra;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h       <= '0;
            r_row     <= '0;
            r_scan    <= '0;
            r_adj     <= '0;
            r_ra      <= '0;
            r_rsa     <= '0;
            r_disp    <= 1'b0;
            r_vdisp   <= 1'b0;
            r_cl_on   <= 1'b0;
            r_cl_done <= 1'b0;
            r_blink   <= 1'b0;
            r_frame   <= '0;
            r_vs_left <= '0;
            r_vs_rel  <= 1'b0;
            r_vs_out  <= 1'b0;
            r_fodd    <= 1'b0;
            r_half    <= 1'b0;
            r_field   <= 1'b0;
        end else begin
            r_h       <= n_h;
            r_row     <= n_row;
            r_scan    <= n_scan;
            r_adj     <= n_adj;
            r_ra      <= n_ra;
            r_rsa     <= n_rsa;
            r_disp    <= n_disp;
            r_vdisp   <= n_vdisp;
            r_cl_on   <= n_cl_on;
            r_cl_done <= n_cl_done;
            r_blink   <= n_blink;
            r_frame   <= n_frame;
            r_vs_left <= n_vs_left;
            r_vs_rel  <= n_vs_rel;
            r_vs_out  <= n_vs_out;
            r_fodd    <= n_fodd;
            r_half    <= n_half;
            r_field   <= n_field;
        end
    end

    // a running vsync count always goes with the vsync level high
    a_vsync_count_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vs_left != '0) |-> r_vs_out)
        else $error("vsync count running with vsync low");

    // cursor line cannot be both on and finished
    a_cursor_line_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_cl_on && r_cl_done))
        else $error("cursor line on after its end line");

    // counters only move on a tick
    a_hold_without_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tick |=> $stable(r_h) && $stable(r_ra) && $stable(r_scan))
        else $error("timing state changed without a tick");

endmodule

`default_nettype wire

/* rtl/crt_controller_timing_unit.sv */
// ----------------------------------------------------------------------------
// crt_controller_timing_unit
// 6845 style crt controller: bus access to the control registers and
// character clock timing, one command word in and one result word out.
//
//   channel  dir  word                                       accepted when
//   i_cmd    in   action, reg_select, write_data             valid && ready
//   o_res    out  read_data, mem_address, row_address,       valid && ready
//                 display_enable, cursor_active, hsync_start,
//                 vsync_level, odd_field
//
// one command word per clock while o_res is not stalled: input register,
// register file and counter logic, result register.
// the result register holds a word while o_res is stalled; the input register
// keeps accepting as long as the step ahead of it can move.
// synchronous active-low reset restores the register file (R9 = 10) and
// clears all counters; the unit accepts commands in the cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module crt_controller_timing_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    crtc_cmd_if.sink    i_cmd,
    crtc_res_if.source  o_res
);

    logic                 r_in_valid;
    crtc_pkg::t_action    r_in_action;
    logic                 r_in_sel;
    logic [7:0]           r_in_data;

    logic                 r_out_valid;
    logic [7:0]           r_out_rd;
    crtc_pkg::t_tim_res   r_out_tim;

    logic                 w_step;
    logic                 w_tick;
    logic [7:0]           w_read_data;
    logic [13:0]          w_refresh_addr;
    crtc_pkg::t_crtc_cfg  w_cfg;
    crtc_pkg::t_tim_res   w_tim;

    assign w_step = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_tick = w_step && (r_in_action == crtc_pkg::ACT_TICK);
    assign i_cmd.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_action <= crtc_pkg::t_action'(i_cmd.action);
            r_in_sel    <= i_cmd.reg_select;
            r_in_data   <= i_cmd.write_data;
        end
    end

    crtc_regfile u_regfile (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_action       (r_in_action),
        .i_reg_select   (r_in_sel),
        .i_write_data   (r_in_data),
        .i_refresh_addr (w_refresh_addr),
        .o_read_data    (w_read_data),
        .o_cfg          (w_cfg)
    );

    crtc_timing u_timing (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (w_tick),
        .i_cfg          (w_cfg),
        .o_res          (w_tim),
        .o_refresh_addr (w_refresh_addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_rd  <= w_read_data;
            r_out_tim <= w_tim;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.read_data      = r_out_rd;
    assign o_res.mem_address    = r_out_tim.mem_address;
    assign o_res.row_address    = r_out_tim.row_address;
    assign o_res.display_enable = r_out_tim.display_enable;
    assign o_res.cursor_active  = r_out_tim.cursor_active;
    assign o_res.hsync_start    = r_out_tim.hsync_start;
    assign o_res.vsync_level    = r_out_tim.vsync_level;
    assign o_res.odd_field      = r_out_tim.odd_field;

    // input register only blocks while it holds a word that cannot move
    a_ready_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.ready |-> (r_in_valid && r_out_valid && !o_res.ready))
        else $error("input stalled without a full pipeline");

    // every step lands in the result register
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("step produced no result word");

    // only bus reads return data
    a_read_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_in_action != crtc_pkg::ACT_READ)) |=> (r_out_rd == '0))
        else $error("read data on a non-read word");

    // cursor and hsync only come from ticks
    a_tick_only_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !w_tick) |=> (!r_out_tim.cursor_active && !r_out_tim.hsync_start))
        else $error("tick flags on a non-tick word");

endmodule

`default_nettype wire
